### hw/rtl/bgd_pkg.sv
// Package for the button gesture detector: event codes, register indexes,
// reset values and the state and configuration structs. No dependencies.
package bgd_pkg;

  typedef enum logic [2:0] {
    EV_NONE   = 3'd0,
    EV_CLICK  = 3'd1,
    EV_DOUBLE = 3'd2,
    EV_HOLD   = 3'd3,
    EV_LONG   = 3'd4
  } event_e;

  localparam int unsigned CfgIdxW = 2;
  localparam int unsigned CfgW    = 16;
  localparam int unsigned TimeW   = 32;

  localparam logic [CfgIdxW-1:0] REG_DOUBLE   = 2'd0;
  localparam logic [CfgIdxW-1:0] REG_HOLD     = 2'd1;
  localparam logic [CfgIdxW-1:0] REG_LONG     = 2'd2;
  localparam logic [CfgIdxW-1:0] REG_DEBOUNCE = 2'd3;

  localparam logic [CfgW-1:0] DOUBLE_RST   = 16'd250;
  localparam logic [CfgW-1:0] HOLD_RST     = 16'd1000;
  localparam logic [CfgW-1:0] LONG_RST     = 16'd3000;
  localparam logic [CfgW-1:0] DEBOUNCE_RST = 16'd50;

  typedef struct packed {
    logic [CfgW-1:0] double_ms;
    logic [CfgW-1:0] hold_ms;
    logic [CfgW-1:0] long_ms;
    logic [CfgW-1:0] debounce_ms;
  } cfg_t;

  typedef struct packed {
    logic             last_level;
    logic [TimeW-1:0] release_time;
    logic [TimeW-1:0] press_time;
    logic             single_pending;
    logic             ignore_release;
    logic             double_armed;
    logic             double_waiting;
    logic             hold_seen;
    logic             long_seen;
  } state_t;

endpackage

### hw/rtl/bgd_cfg_regs.sv
// Configuration register file of the button gesture detector.
// Depends on bgd_pkg.
module bgd_cfg_regs (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       wr_en_i,
  input  logic [bgd_pkg::CfgIdxW-1:0] wr_index_i,
  input  logic [bgd_pkg::CfgW-1:0]    wr_data_i,
  output bgd_pkg::cfg_t              cfg_o
);

  bgd_pkg::cfg_t cfg_q, cfg_d;

  always_comb begin
    cfg_d = cfg_q;
    if (wr_en_i) begin
      case (wr_index_i)
        bgd_pkg::REG_DOUBLE:   cfg_d.double_ms   = wr_data_i;
        bgd_pkg::REG_HOLD:     cfg_d.hold_ms     = wr_data_i;
        bgd_pkg::REG_LONG:     cfg_d.long_ms     = wr_data_i;
        bgd_pkg::REG_DEBOUNCE: cfg_d.debounce_ms = wr_data_i;
        default:               cfg_d = cfg_q;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.double_ms   <= bgd_pkg::DOUBLE_RST;
      cfg_q.hold_ms     <= bgd_pkg::HOLD_RST;
      cfg_q.long_ms     <= bgd_pkg::LONG_RST;
      cfg_q.debounce_ms <= bgd_pkg::DEBOUNCE_RST;
    end else begin
      cfg_q <= cfg_d;
    end
  end

  assign cfg_o = cfg_q;

endmodule

### hw/rtl/bgd_eval.sv
// Combinational evaluation of one button sample: next state and event code.
// Depends on bgd_pkg.
module bgd_eval (
  input  logic                       level_i,
  input  logic [bgd_pkg::TimeW-1:0]  now_ms_i,
  input  bgd_pkg::cfg_t              cfg_i,
  input  bgd_pkg::state_t            state_i,
  output bgd_pkg::state_t            state_o,
  output bgd_pkg::event_e            event_o
);

  logic [bgd_pkg::TimeW-1:0] up_gap0, dn_gap0, up_gap1, dn_gap1;
  logic [bgd_pkg::TimeW-1:0] dbl_w, hold_w, long_w, deb_w;
  logic                      press_edge, release_edge, rise;
  bgd_pkg::state_t           s;
  bgd_pkg::event_e           ev;

  assign dbl_w  = bgd_pkg::TimeW'(cfg_i.double_ms);
  assign hold_w = bgd_pkg::TimeW'(cfg_i.hold_ms);
  assign long_w = bgd_pkg::TimeW'(cfg_i.long_ms);
  assign deb_w  = bgd_pkg::TimeW'(cfg_i.debounce_ms);

  assign up_gap0 = now_ms_i - state_i.release_time;
  assign dn_gap0 = now_ms_i - state_i.press_time;
  assign rise    = level_i && !state_i.last_level;
  assign press_edge   = !level_i && state_i.last_level && (up_gap0 > deb_w);
  assign release_edge = !press_edge && rise && (dn_gap0 > deb_w);

  always_comb begin
    s  = state_i;
    ev = bgd_pkg::EV_NONE;
    if (press_edge) begin
      s.press_time     = now_ms_i;
      s.single_pending = 1'b1;
      s.ignore_release = 1'b0;
      s.hold_seen      = 1'b0;
      s.long_seen      = 1'b0;
      s.double_armed   = (up_gap0 < dbl_w) && !state_i.double_armed && state_i.double_waiting;
      s.double_waiting = 1'b0;
    end else if (release_edge && !state_i.ignore_release) begin
      s.release_time = now_ms_i;
      if (!state_i.double_armed) begin
        s.double_waiting = 1'b1;
      end else begin
        ev               = bgd_pkg::EV_DOUBLE;
        s.double_armed   = 1'b0;
        s.double_waiting = 1'b0;
        s.single_pending = 1'b0;
      end
    end

    if (level_i && (up_gap1 > dbl_w) && !s.double_armed && s.double_waiting
        && s.single_pending) begin
      ev               = bgd_pkg::EV_CLICK;
      s.double_waiting = 1'b0;
    end

    if (rise && (dn_gap1 > hold_w) && (dn_gap1 < long_w)) begin
      ev = bgd_pkg::EV_HOLD;
    end

    if (!level_i && (dn_gap1 > hold_w)) begin
      if (!s.hold_seen) begin
        s.ignore_release = 1'b1;
        s.hold_seen      = 1'b1;
      end
      if ((dn_gap1 > long_w) && !s.long_seen) begin
        s.long_seen = 1'b1;
        ev          = bgd_pkg::EV_LONG;
      end
    end

    s.last_level = level_i;
  end

  // gaps after the edge updates; only the edge that fired moves a timestamp
  assign up_gap1 = (release_edge && !state_i.ignore_release) ? '0 : up_gap0;
  assign dn_gap1 = press_edge ? '0 : dn_gap0;

  assign state_o = s;
  assign event_o = ev;

endmodule

### hw/rtl/button_gesture_detector.sv
// Top level of the button gesture detector: input register, state registers,
// result register. Depends on bgd_pkg, bgd_cfg_regs and bgd_eval.
//
//  channel | signals                              | direction
//  in      | in_valid_i, in_ready_o, level_i, now_ms_i | sample in
//  out     | out_valid_o, out_ready_i, event_code_o    | event out
//  cfg     | cfg_valid_i, cfg_ready_o, cfg_index_i, cfg_data_i | register write
//
// A sample passes through the input register and then the result register.
// One sample per cycle is sustained while out_ready_i is high; the state update is a single pass of bgd_eval.
// Reset sets last_level to released, times and flags to zero, registers to defaults.
// A stalled result holds the result register; the input register fills behind it
// and in_ready_o drops only when both are full.
module button_gesture_detector (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        in_valid_i,
  output logic                        in_ready_o,
  input  logic                        level_i,
  input  logic [bgd_pkg::TimeW-1:0]   now_ms_i,
  output logic                        out_valid_o,
  input  logic                        out_ready_i,
  output logic [2:0]                  event_code_o,
  input  logic                        cfg_valid_i,
  output logic                        cfg_ready_o,
  input  logic [bgd_pkg::CfgIdxW-1:0] cfg_index_i,
  input  logic [bgd_pkg::CfgW-1:0]    cfg_data_i
);

  bgd_pkg::cfg_t             cfg;
  bgd_pkg::state_t           st_q, st_d;
  bgd_pkg::event_e           ev_d, ev_q;
  logic                      in_valid_q, out_valid_q, advance;
  logic                      level_q;
  logic [bgd_pkg::TimeW-1:0] now_q;

  assign cfg_ready_o = 1'b1;

  bgd_cfg_regs u_cfg (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .wr_en_i    (cfg_valid_i),
    .wr_index_i (cfg_index_i),
    .wr_data_i  (cfg_data_i),
    .cfg_o      (cfg)
  );

  bgd_eval u_eval (
    .level_i  (level_q),
    .now_ms_i (now_q),
    .cfg_i    (cfg),
    .state_i  (st_q),
    .state_o  (st_d),
    .event_o  (ev_d)
  );

  assign advance    = in_valid_q && (!out_valid_q || out_ready_i);
  assign in_ready_o = !in_valid_q || advance;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
      st_q        <= '{last_level: 1'b1, default: '0};
    end else begin
      if (in_ready_o) begin
        in_valid_q <= in_valid_i;
      end
      if (advance) begin
        out_valid_q <= 1'b1;
        st_q        <= st_d;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_ready_o && in_valid_i) begin
      level_q <= level_i;
      now_q   <= now_ms_i;
    end
    if (advance) begin
      ev_q <= ev_d;
    end
  end

  assign out_valid_o  = out_valid_q;
  assign event_code_o = 3'(ev_q);

  a_long_sets_flag: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q && (ev_q == bgd_pkg::EV_LONG) |-> st_q.long_seen)
    else $error("long hold without long_seen");

  a_long_implies_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    st_q.long_seen |-> st_q.hold_seen)
    else $error("long_seen without hold_seen");

  a_double_clears: assert property (@(posedge clk_i) disable iff (!rst_ni)
    advance && (ev_d == bgd_pkg::EV_DOUBLE) |=> !st_q.double_armed && !st_q.double_waiting)
    else $error("double click left window armed");

  a_no_drop: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_q && !advance |=> in_valid_q)
    else $error("pending sample lost");

endmodule
